/* sv/ball_model_point_converter_top_macros.svh */
// assertion macros for the ball model point converter
// used by ball_model_point_converter_top; expects i_clk and i_rst_n in scope
`ifndef BALL_MODEL_POINT_CONVERTER_TOP_MACROS_SVH
`define BALL_MODEL_POINT_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BMPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BMPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bmpc_pkg.sv */
// shared constants and types of the ball model point converter
// no dependencies
package bmpc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 30;

    localparam int             EPS_WIDTH  = 31;
    localparam logic [30:0]    EPS_RESET  = 31'd1074;
    localparam int             CFG_ADDR_W = 3;
    localparam int             CFG_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_EPSILON = 1'b0;

    // conversion direction
    typedef enum logic {
        DIR_K2P = 1'b0,
        DIR_P2K = 1'b1
    } t_dir;

endpackage

/* sv/bmpc_sqrt_cell.sv */
// one cell of the square root chain: settles one root bit for two lanes
// depends on bmpc_pkg
module bmpc_sqrt_cell #(
    parameter int W      = bmpc_pkg::COORD_WIDTH_DEF,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [1:0][2*W-1:0]     i_rem,
    input  logic [1:0][W-1:0]       i_root,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [1:0][2*W-1:0]     o_rem,
    output logic [1:0][W-1:0]       o_root,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int SW = 2 * W;

    logic                r_v;
    logic [1:0][SW-1:0]  r_rem;
    logic [1:0][W-1:0]   r_root;
    logic [SIDE_W-1:0]   r_side;
    logic [1:0][SW-1:0]  n_rem;
    logic [1:0][W-1:0]   n_root;
    logic [1:0][SW-1:0]  trial;

    // trial = (2*root + 2^bit) * 2^bit against remainder n - root^2
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l] = (SW'(i_root[l]) << (BIT + 1)) | (SW'(1) << (2 * BIT));
            if (i_rem[l] >= trial[l]) begin
                n_rem[l]  = i_rem[l] - trial[l];
                n_root[l] = i_root[l] | (W'(1) << BIT);
            end else begin
                n_rem[l]  = i_rem[l];
                n_root[l] = i_root[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

/* sv/bmpc_div_cell.sv */
// one cell of the divider chain: settles one quotient bit for three lanes
// depends on bmpc_pkg
module bmpc_div_cell #(
    parameter int W      = bmpc_pkg::COORD_WIDTH_DEF,
    parameter int F      = bmpc_pkg::FRAC_BITS_DEF,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2:0][W+F:0]       i_num,
    input  logic [W-1:0]            i_den,
    input  logic [2:0][F+1:0]       i_quo,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [2:0][W+F:0]       o_num,
    output logic [W-1:0]            o_den,
    output logic [2:0][F+1:0]       o_quo,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int NW = W + F + 1;
    localparam int QW = F + 2;

    logic                r_v;
    logic [2:0][NW-1:0]  r_num;
    logic [W-1:0]        r_den;
    logic [2:0][QW-1:0]  r_quo;
    logic [SIDE_W-1:0]   r_side;
    logic [2:0][NW-1:0]  n_num;
    logic [2:0][QW-1:0]  n_quo;
    logic [NW-1:0]       den_sh;

    always_comb begin
        den_sh = NW'(i_den) << BIT;
        for (int l = 0; l < 3; l++) begin
            if (i_num[l] >= den_sh) begin
                n_num[l] = i_num[l] - den_sh;
                n_quo[l] = i_quo[l] | (QW'(1) << BIT);
            end else begin
                n_num[l] = i_num[l];
                n_quo[l] = i_quo[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_den  <= i_den;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

/* sv/ball_model_point_converter_top.sv */
// top level of the ball model point converter (klein <-> poincare)
// depends on bmpc_pkg, bmpc_sqrt_cell, bmpc_div_cell and the macros header
//
// channel   direction  handshake             payload
// input     in         i_valid / o_ready     i_req_type, i_x_in, i_y_in, i_z_in
// output    out        o_valid / i_ready     o_x_out, o_y_out, o_z_out, o_boundary_clamped
// config    in         psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// one point enters per cycle while o_ready is high; the chain has one sqrt cell
// per root bit and one divider cell per quotient bit. reset is synchronous,
// active low, clears valid bits and epsilon to 1074. when the output stalls,
// a skid register takes one more result and then the whole chain holds;
// o_ready drops only while the skid is full
`include "ball_model_point_converter_top_macros.svh"

module ball_model_point_converter_top #(
    parameter int COORD_WIDTH = bmpc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = bmpc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input requests
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic signed [COORD_WIDTH-1:0]       i_x_in,
    input  logic signed [COORD_WIDTH-1:0]       i_y_in,
    input  logic signed [COORD_WIDTH-1:0]       i_z_in,
    // results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_WIDTH-1:0]       o_x_out,
    output logic signed [COORD_WIDTH-1:0]       o_y_out,
    output logic signed [COORD_WIDTH-1:0]       o_z_out,
    output logic                                o_boundary_clamped,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bmpc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bmpc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bmpc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * W;          // squared radius
    localparam int NW = W + F + 1;      // divider numerator
    localparam int QW = F + 2;          // quotient
    localparam int PW = W + QW;         // coordinate times scale
    localparam int MW = PW + 1 - F;     // rounded magnitude
    localparam int EW = bmpc_pkg::EPS_WIDTH;

    localparam logic [W-1:0]  ONE      = W'(1) << F;
    localparam logic [SW-1:0] ONE_SQ_S = SW'(1) << (2 * F);
    localparam logic [SW-1:0] HALF_S   = SW'(1) << (F - 1);
    localparam logic [NW-1:0] ONE_SQ   = NW'(1) << (2 * F);
    localparam logic [NW-1:0] TWO_SQ   = NW'(1) << (2 * F + 1);
    localparam logic [PW:0]   HALF_P   = (PW + 1)'(1) << (F - 1);
    localparam logic [MW-1:0] SAT_NEG  = MW'(1) << (W - 1);
    localparam logic [MW-1:0] SAT_POS  = SAT_NEG - MW'(1);
    // 0.9999 rounded to the fraction grid
    localparam logic [F-1:0]  CLAMP_R  =
        F'(((64'd9999 << F) + 64'd5000) / 64'd10000);

    typedef struct packed {
        bmpc_pkg::t_dir        dir;
        logic [2:0]            neg;
        logic [2:0][W-1:0]     mag;
        logic [W-1:0]          dq;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][W-1:0]     mag;
        logic                  clamp;
        logic                  zero;
    } t_div_side;

    typedef struct packed {
        logic [2:0][W-1:0]     coord;
        logic                  flag;
    } t_res;

    // global advance: the chain moves unless the skid is holding a result
    logic en;
    logic r_skid_v;
    logic r_out_v;
    t_res r_out;
    t_res r_skid;

    assign en      = !r_skid_v;
    assign o_ready = en;

    // ---------------- configuration ----------------
    logic [EW-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= bmpc_pkg::EPS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == bmpc_pkg::REG_EPSILON)) begin
            r_eps <= pwdata[EW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bmpc_pkg::REG_EPSILON) ?
                    bmpc_pkg::CFG_DATA_W'(r_eps) : '0;

    // ---------------- stage a: sign and magnitude ----------------
    logic [2:0][W-1:0] in_v;
    logic [2:0][W-1:0] in_mag;
    logic [2:0]        in_neg;

    assign in_v = {i_z_in, i_y_in, i_x_in};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_neg[i] = in_v[i][W-1];
            in_mag[i] = in_neg[i] ? (~in_v[i] + W'(1)) : in_v[i];
        end
    end

    logic               r_a_v;
    bmpc_pkg::t_dir     r_a_dir;
    logic [2:0]         r_a_neg;
    logic [2:0][W-1:0]  r_a_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dir <= bmpc_pkg::t_dir'(i_req_type);
            r_a_neg <= in_neg;
            r_a_mag <= in_mag;
        end
    end

    // ---------------- stage b: squares ----------------
    logic               r_b_v;
    bmpc_pkg::t_dir     r_b_dir;
    logic [2:0]         r_b_neg;
    logic [2:0][W-1:0]  r_b_mag;
    logic [2:0][SW-1:0] r_b_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_dir <= r_a_dir;
            r_b_neg <= r_a_neg;
            r_b_mag <= r_a_mag;
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i] <= SW'(r_a_mag[i]) * SW'(r_a_mag[i]);
            end
        end
    end

    // ---------------- stage c: sum of squares ----------------
    logic               r_c_v;
    bmpc_pkg::t_dir     r_c_dir;
    logic [2:0]         r_c_neg;
    logic [2:0][W-1:0]  r_c_mag;
    logic [SW-1:0]      r_c_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_dir <= r_b_dir;
            r_c_neg <= r_b_neg;
            r_c_mag <= r_b_mag;
            r_c_sq  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        end
    end

    // ---------------- stage d: 1 - r^2 and the poincare denominator ----------------
    logic            r_d_v;
    t_sq_side        r_d_side;
    logic [SW-1:0]   r_d_sq;
    logic [SW-1:0]   r_d_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sq        <= r_c_sq;
            // only meaningful inside the unit ball
            r_d_t         <= (r_c_sq < ONE_SQ_S) ? (ONE_SQ_S - r_c_sq) : '0;
            r_d_side.dir  <= r_c_dir;
            r_d_side.neg  <= r_c_neg;
            r_d_side.mag  <= r_c_mag;
            r_d_side.dq   <= ONE + W'((r_c_sq + HALF_S) >> F);
        end
    end

    // ---------------- square root chain: r from r^2, s from 1 - r^2 ----------------
    logic               sq_v    [0:W];
    logic [1:0][SW-1:0] sq_rem  [0:W];
    logic [1:0][W-1:0]  sq_root [0:W];
    t_sq_side           sq_side [0:W];

    assign sq_v[0]    = r_d_v;
    assign sq_rem[0]  = {r_d_t, r_d_sq};
    assign sq_root[0] = '0;
    assign sq_side[0] = r_d_side;

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        bmpc_sqrt_cell #(
            .W      (W),
            .BIT    (W - 1 - k),
            .SIDE_W ($bits(t_sq_side))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // ---------------- stage e1: case decision, clamp products, divisor ----------------
    logic [W-1:0] rad;
    logic [W-1:0] srt;
    t_sq_side     sq_out;
    logic         is_clamp;
    logic         is_zero;

    assign rad      = sq_root[W][0];
    assign srt      = sq_root[W][1];
    assign sq_out   = sq_side[W];
    // boundary test wins over the epsilon test
    assign is_clamp = (rad >= ONE);
    assign is_zero  = !is_clamp && ({{EW{1'b0}}, rad} <= {{W{1'b0}}, r_eps});

    logic                 r_e1_v;
    logic                 r_e1_clamp;
    logic                 r_e1_zero;
    bmpc_pkg::t_dir       r_e1_dir;
    logic [2:0]           r_e1_neg;
    logic [2:0][W-1:0]    r_e1_mag;
    logic [2:0][W+F-1:0]  r_e1_prod;
    logic [W-1:0]         r_e1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (en) begin
            r_e1_v <= sq_v[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1_clamp <= is_clamp;
            r_e1_zero  <= is_zero;
            r_e1_dir   <= sq_out.dir;
            r_e1_neg   <= sq_out.neg;
            r_e1_mag   <= sq_out.mag;
            for (int i = 0; i < 3; i++) begin
                r_e1_prod[i] <= (W + F)'(sq_out.mag[i]) * (W + F)'(CLAMP_R);
            end
            if (is_clamp) begin
                r_e1_d <= rad;
            end else if (sq_out.dir == bmpc_pkg::DIR_P2K) begin
                r_e1_d <= sq_out.dq;
            end else begin
                r_e1_d <= ONE + srt;
            end
        end
    end

    // ---------------- stage e2: rounded numerators ----------------
    logic               r_e2_v;
    logic [2:0][NW-1:0] r_e2_num;
    logic [W-1:0]       r_e2_d;
    t_div_side          r_e2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else if (en) begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_e1_clamp) begin
                    r_e2_num[i] <= NW'(r_e1_prod[i]) + NW'(r_e1_d >> 1);
                end else if (r_e1_dir == bmpc_pkg::DIR_P2K) begin
                    r_e2_num[i] <= TWO_SQ + NW'(r_e1_d >> 1);
                end else begin
                    r_e2_num[i] <= ONE_SQ + NW'(r_e1_d >> 1);
                end
            end
            r_e2_d          <= r_e1_d;
            r_e2_side.neg   <= r_e1_neg;
            r_e2_side.mag   <= r_e1_mag;
            r_e2_side.clamp <= r_e1_clamp;
            r_e2_side.zero  <= r_e1_zero;
        end
    end

    // ---------------- divider chain: clamped coordinates or the common scale ----------------
    logic               dv_v    [0:QW];
    logic [2:0][NW-1:0] dv_num  [0:QW];
    logic [W-1:0]       dv_den  [0:QW];
    logic [2:0][QW-1:0] dv_quo  [0:QW];
    t_div_side          dv_side [0:QW];

    assign dv_v[0]    = r_e2_v;
    assign dv_num[0]  = r_e2_num;
    assign dv_den[0]  = r_e2_d;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = r_e2_side;

    for (genvar k = 0; k < QW; k++) begin : g_div
        bmpc_div_cell #(
            .W      (W),
            .F      (F),
            .BIT    (QW - 1 - k),
            .SIDE_W ($bits(t_div_side))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[k]),
            .i_num   (dv_num[k]),
            .i_den   (dv_den[k]),
            .i_quo   (dv_quo[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_v[k+1]),
            .o_num   (dv_num[k+1]),
            .o_den   (dv_den[k+1]),
            .o_quo   (dv_quo[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    // ---------------- stage f: coordinate times scale ----------------
    logic               r_f_v;
    logic [2:0][PW-1:0] r_f_prod;
    logic [2:0][QW-1:0] r_f_quo;
    t_div_side          r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_f_prod[i] <= PW'(dv_side[QW].mag[i]) * PW'(dv_quo[QW][i]);
            end
            r_f_quo  <= dv_quo[QW];
            r_f_side <= dv_side[QW];
        end
    end

    // rounding, zeroing, saturation and sign restore
    t_res              res;
    logic [2:0][MW-1:0] mag_r;
    logic [2:0][MW-1:0] mag_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_f_side.zero) begin
                mag_r[i] = '0;
            end else if (r_f_side.clamp) begin
                mag_r[i] = MW'(r_f_quo[i]);
            end else begin
                mag_r[i] = MW'(({1'b0, r_f_prod[i]} + HALF_P) >> F);
            end
            if (r_f_side.neg[i]) begin
                mag_s[i]        = (mag_r[i] > SAT_NEG) ? SAT_NEG : mag_r[i];
                res.coord[i]    = W'(MW'(0) - mag_s[i]);
            end else begin
                mag_s[i]        = (mag_r[i] > SAT_POS) ? SAT_POS : mag_r[i];
                res.coord[i]    = W'(mag_s[i]);
            end
        end
        res.flag = r_f_side.clamp;
    end

    // ---------------- output register with skid ----------------
    logic take;
    logic push;

    assign take = r_out_v && i_ready;
    assign push = en && r_f_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_v || take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_valid            = r_out_v;
    assign o_x_out            = r_out.coord[0];
    assign o_y_out            = r_out.coord[1];
    assign o_z_out            = r_out.coord[2];
    assign o_boundary_clamped = r_out.flag;

    // ---------------- assertions ----------------
    `BMPC_ASSERT_SAME(a_skid_behind_out, r_skid_v, r_out_v,
        "skid holds a result while the output register is empty")
    `BMPC_ASSERT_NEXT(a_skid_drains, r_skid_v && i_ready, r_out_v && !r_skid_v,
        "skid did not move into the output register")
    `BMPC_ASSERT_SAME(a_clamp_excludes_zero, r_f_v && r_f_side.clamp, !r_f_side.zero,
        "clamped point also marked as below epsilon")

endmodule
